// ===== sv/spse_pkg.sv =====
`timescale 1ns / 1ps

package spse_pkg;

   // block limits
   localparam int SYMBOL_CAP   = 48;
   localparam int DURATION_MAX = 32767;

   // field widths
   localparam int WORD_W     = 32;
   localparam int DUR_W      = 15;
   localparam int PULSE_W    = 15;
   localparam int MINP_W     = 16;
   localparam int BUDGET_W   = 6;
   localparam int TOTAL_W    = 6;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // counter widths derived from the symbol limit
   localparam int CNT_W = $clog2(SYMBOL_CAP + 1);
   localparam int PER_W = $clog2(SYMBOL_CAP + 2);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PULSE_TICKS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PERIOD  = 1'b1;

   typedef enum logic {
      KIND_SYMBOL = 1'b0,
      KIND_DONE   = 1'b1
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic prep;
      logic scan;
      logic start_step;
      logic emit_first;
      logic emit_mid;
      logic emit_done;
   } spse_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic scan_more;
      logic step_ok;
      logic idle_small;
      logic idle_big;
   } spse_status_type;

   // one result beat
   typedef struct packed {
      kind_type             kind;
      logic                 first_level;
      logic [DUR_W-1:0]     first_duration;
      logic                 second_level;
      logic [DUR_W-1:0]     second_duration;
      logic [TOTAL_W-1:0]   total_symbols;
      logic [TOTAL_W-1:0]   steps_done;
      logic                 last;
   } spse_item_type;

endpackage

// ===== sv/spse_req_if.sv =====
`timescale 1ns / 1ps

interface spse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] step_period;
   logic [31:0] num_steps;
   logic [5:0]  symbol_budget;

   modport source (output valid, output step_period, output num_steps,
                   output symbol_budget, input ready);
   modport sink   (input valid, input step_period, input num_steps,
                   input symbol_budget, output ready);
endinterface

// ===== sv/spse_rsp_if.sv =====
`timescale 1ns / 1ps

interface spse_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        first_level;
   logic [14:0] first_duration;
   logic        second_level;
   logic [14:0] second_duration;
   logic [5:0]  total_symbols;
   logic [5:0]  steps_done;
   logic        last;

   modport source (output valid, output kind, output first_level, output first_duration,
                   output second_level, output second_duration, output total_symbols,
                   output steps_done, output last, input ready);
   modport sink   (input valid, input kind, input first_level, input first_duration,
                   input second_level, input second_duration, input total_symbols,
                   input steps_done, input last, output ready);
endinterface

// ===== sv/spse_ctrl.sv =====
`timescale 1ns / 1ps

module spse_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  spse_pkg::spse_status_type status,
   output spse_pkg::spse_cmd_type    cmd
);
   import spse_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_PREP  = 7'b0000010,
      S_SCAN  = 7'b0000100,
      S_STEP  = 7'b0001000,
      S_FIRST = 7'b0010000,
      S_MID   = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_more) begin
               cmd.scan = 1'b1;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (status.step_ok) begin
               cmd.start_step = 1'b1;
               state_in       = S_FIRST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_FIRST: begin
            if (status.out_free) begin
               cmd.emit_first = 1'b1;
               state_in       = status.idle_small ? S_STEP : S_MID;
            end
         end
         S_MID: begin
            if (status.out_free) begin
               cmd.emit_mid = 1'b1;
               state_in     = status.idle_big ? S_MID : S_STEP;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit_done = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/spse_datapath.sv =====
`timescale 1ns / 1ps

module spse_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [spse_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [spse_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [spse_pkg::WORD_W-1:0]          step_period,
   input  logic [spse_pkg::WORD_W-1:0]          num_steps,
   input  logic [spse_pkg::BUDGET_W-1:0]        symbol_budget,
   input  spse_pkg::spse_cmd_type               cmd,
   output spse_pkg::spse_status_type            status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output spse_pkg::spse_item_type              rsp_item
);
   import spse_pkg::*;

   localparam logic [WORD_W-1:0] DMAX_W     = WORD_W'(DURATION_MAX);
   localparam logic [WORD_W-1:0] TWO_DMAX_W = WORD_W'(2 * DURATION_MAX);
   localparam logic [DUR_W-1:0]  DMAX_D     = DUR_W'(DURATION_MAX);
   localparam logic [PER_W-1:0]  PER_SAT    = PER_W'(SYMBOL_CAP + 1);
   localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(SYMBOL_CAP);

   logic [PULSE_W-1:0] pulse_ff, pulse_in;
   logic [MINP_W-1:0]  min_period_ff, min_period_in;
   logic [WORD_W-1:0]  period_ff, period_in;
   logic [WORD_W-1:0]  idle_ff, idle_in;
   logic [WORD_W-1:0]  scan_ff, scan_in;
   logic [PER_W-1:0]   per_step_ff, per_step_in;
   logic [CNT_W-1:0]   budget_left_ff, budget_left_in;
   logic [WORD_W-1:0]  steps_left_ff, steps_left_in;
   logic [WORD_W-1:0]  idle_left_ff, idle_left_in;
   logic [CNT_W-1:0]   symbol_total_ff, symbol_total_in;
   logic [CNT_W-1:0]   step_total_ff, step_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   spse_item_type      item_ff, item_in;

   logic               out_free;
   logic [DUR_W-1:0]   pulse_sat;
   logic [WORD_W-1:0]  idle_calc;
   logic [WORD_W-1:0]  idle_minus_dmax;
   logic               idle_small;
   logic               idle_big;
   logic               emit_sym;

   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign pulse_sat       = (pulse_ff > DMAX_D) ? DMAX_D : pulse_ff;
   assign idle_calc       = (period_ff > WORD_W'(pulse_ff)) ?
                            (period_ff - WORD_W'(pulse_ff)) : '0;
   assign idle_minus_dmax = idle_left_ff - DMAX_W;
   assign idle_small      = idle_left_ff <= DMAX_W;
   assign idle_big        = idle_left_ff > TWO_DMAX_W;
   assign emit_sym        = cmd.emit_first || cmd.emit_mid;

   // status back to the controller
   always_comb begin
      status.out_free   = out_free;
      status.scan_more  = (scan_ff > DMAX_W) && (per_step_ff < PER_SAT);
      status.step_ok    = (steps_left_ff != '0) && (per_step_ff <= PER_W'(budget_left_ff));
      status.idle_small = idle_small;
      status.idle_big   = idle_big;
   end

   // configuration writes
   always_comb begin
      pulse_in      = pulse_ff;
      min_period_in = min_period_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PULSE_TICKS: pulse_in      = csr_wdata[PULSE_W-1:0];
            CSR_MIN_PERIOD:  min_period_in = csr_wdata[MINP_W-1:0];
            default: begin
               pulse_in = pulse_ff;
            end
         endcase
      end
   end

   // batch setup and symbol count of one step
   always_comb begin
      period_in      = period_ff;
      idle_in        = idle_ff;
      scan_in        = scan_ff;
      per_step_in    = per_step_ff;
      budget_left_in = budget_left_ff;
      steps_left_in  = steps_left_ff;
      step_total_in  = step_total_ff;
      if (cmd.load) begin
         period_in      = (step_period < WORD_W'(min_period_ff)) ?
                          WORD_W'(min_period_ff) : step_period;
         budget_left_in = (CNT_W'(symbol_budget) > MAX_CNT) ? MAX_CNT : CNT_W'(symbol_budget);
         steps_left_in  = num_steps;
         step_total_in  = '0;
      end
      if (cmd.prep) begin
         idle_in     = idle_calc;
         scan_in     = idle_calc;
         per_step_in = PER_W'(1);
      end
      // each pass past the first symbol covers two more full halves
      if (cmd.scan) begin
         scan_in     = (scan_ff > TWO_DMAX_W) ? (scan_ff - TWO_DMAX_W) : '0;
         per_step_in = per_step_ff + PER_W'(1);
      end
      if (cmd.start_step) begin
         steps_left_in = steps_left_ff - WORD_W'(1);
         step_total_in = step_total_ff + CNT_W'(1);
      end
      if (emit_sym) begin
         budget_left_in = budget_left_ff - CNT_W'(1);
      end
   end

   // symbol and done beat generation into the output register
   always_comb begin
      idle_left_in    = idle_left_ff;
      symbol_total_in = symbol_total_ff;
      item_in         = item_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (cmd.load) begin
         symbol_total_in = '0;
      end
      if (cmd.start_step) begin
         idle_left_in = idle_ff;
      end
      if (emit_sym) begin
         symbol_total_in       = symbol_total_ff + CNT_W'(1);
         item_in.kind          = KIND_SYMBOL;
         item_in.second_level  = 1'b0;
         item_in.total_symbols = TOTAL_W'(symbol_total_in);
         item_in.steps_done    = TOTAL_W'(step_total_ff);
         item_in.last          = 1'b0;
         rsp_valid_in          = 1'b1;
      end
      // pulse half and the head of the idle time
      if (cmd.emit_first) begin
         item_in.first_level    = 1'b1;
         item_in.first_duration = pulse_sat;
         if (idle_small) begin
            item_in.second_duration = idle_left_ff[DUR_W-1:0];
            idle_left_in            = '0;
         end else begin
            item_in.second_duration = DMAX_D;
            idle_left_in            = idle_minus_dmax;
         end
      end
      // all-low filler or closing fragment
      if (cmd.emit_mid) begin
         item_in.first_level = 1'b0;
         if (idle_big) begin
            item_in.first_duration  = DMAX_D;
            item_in.second_duration = DMAX_D;
            idle_left_in            = idle_left_ff - TWO_DMAX_W;
         end else if (idle_small) begin
            item_in.first_duration  = idle_left_ff[DUR_W-1:0];
            item_in.second_duration = '0;
            idle_left_in            = '0;
         end else begin
            item_in.first_duration  = DMAX_D;
            item_in.second_duration = idle_minus_dmax[DUR_W-1:0];
            idle_left_in            = '0;
         end
      end
      if (cmd.emit_done) begin
         item_in.kind            = KIND_DONE;
         item_in.first_level     = 1'b0;
         item_in.first_duration  = '0;
         item_in.second_level    = 1'b0;
         item_in.second_duration = '0;
         item_in.total_symbols   = TOTAL_W'(symbol_total_ff);
         item_in.steps_done      = TOTAL_W'(step_total_ff);
         item_in.last            = 1'b1;
         rsp_valid_in            = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_ff        <= PULSE_W'(4);
         min_period_ff   <= MINP_W'(8);
         rsp_valid_ff    <= 1'b0;
         budget_left_ff  <= '0;
         steps_left_ff   <= '0;
         idle_left_ff    <= '0;
         symbol_total_ff <= '0;
         step_total_ff   <= '0;
         per_step_ff     <= '0;
      end else begin
         pulse_ff        <= pulse_in;
         min_period_ff   <= min_period_in;
         rsp_valid_ff    <= rsp_valid_in;
         budget_left_ff  <= budget_left_in;
         steps_left_ff   <= steps_left_in;
         idle_left_ff    <= idle_left_in;
         symbol_total_ff <= symbol_total_in;
         step_total_ff   <= step_total_in;
         per_step_ff     <= per_step_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      period_ff <= period_in;
      idle_ff   <= idle_in;
      scan_ff   <= scan_in;
      item_ff   <= item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = item_ff;

endmodule

// ===== sv/step_pulse_symbol_encoder_core.sv =====
`timescale 1ns / 1ps

// Step pulse symbol encoder. Each request beat is one batch (step period, step count,
// symbol budget); the block answers with the batch's two-half pulse-train symbols, one
// response beat per symbol, followed by one done beat carrying the totals. Steps whose
// symbols no longer fit the budget are dropped. Before the steps are encoded, a setup
// loop counts the symbols of one step; each step is then checked against the steps and
// budget left, and the output register moves one symbol per cycle within a step while
// the sink is ready. The next request is taken once the done beat sits in the output
// register. The pulse length and minimum period registers are to be written over the
// csr port only while no batch is in progress; the block itself does not enforce this.
module step_pulse_symbol_encoder_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [spse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spse_pkg::CSR_DATA_W-1:0]   csr_wdata,
   spse_req_if.sink                          req_bus,
   spse_rsp_if.source                        rsp_bus
);
   import spse_pkg::*;

   spse_cmd_type    cmd;
   spse_status_type status;
   spse_item_type   rsp_item;
   logic            rsp_valid;
   logic            req_ready;

   spse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spse_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .step_period   (req_bus.step_period),
      .num_steps     (req_bus.num_steps),
      .symbol_budget (req_bus.symbol_budget),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_bus.ready),
      .rsp_valid     (rsp_valid),
      .rsp_item      (rsp_item)
   );

   // port hookup
   assign req_bus.ready           = req_ready;
   assign rsp_bus.valid           = rsp_valid;
   assign rsp_bus.kind            = rsp_item.kind;
   assign rsp_bus.first_level     = rsp_item.first_level;
   assign rsp_bus.first_duration  = rsp_item.first_duration;
   assign rsp_bus.second_level    = rsp_item.second_level;
   assign rsp_bus.second_duration = rsp_item.second_duration;
   assign rsp_bus.total_symbols   = rsp_item.total_symbols;
   assign rsp_bus.steps_done      = rsp_item.steps_done;
   assign rsp_bus.last            = rsp_item.last;

endmodule

// ===== sv/spse_checker.sv =====
`timescale 1ns / 1ps

module spse_checker (
   input  logic       clock,
   input  logic       reset,
   spse_req_if.sink   req_bus,
   spse_rsp_if.source rsp_bus
);
   import spse_pkg::*;

   // a stalled response beat holds its kind, durations and symbol total
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.ready) |=>
         (rsp_bus.valid && $stable(rsp_bus.kind) && $stable(rsp_bus.first_duration)
          && $stable(rsp_bus.second_duration) && $stable(rsp_bus.total_symbols)))
      else $error("response beat changed while stalled");

   // a batch keeps the request side closed right after it is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a batch is starting");

   // symbols are only produced while a batch is open
   a_symbol_in_batch: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_SYMBOL) |-> !req_bus.ready)
      else $error("symbol pending while request side is open");

   // a symbol beat counts itself and its step and is not last
   a_symbol_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.kind == KIND_SYMBOL) |->
         (rsp_bus.total_symbols != '0 && rsp_bus.steps_done != '0 && !rsp_bus.last))
      else $error("symbol beat with bad running counts");

endmodule

bind step_pulse_symbol_encoder_core spse_checker u_spse_checker (
   .clock   (clock),
   .reset   (reset),
   .req_bus (req_bus),
   .rsp_bus (rsp_bus)
);
